/* hw/rtl/packbits_row_encoder_macros.svh */
// ----------------------------------------------------------------------------
// PackBits row encoder assertion macros
// Shared assertion forms for the checker of the row encoder.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_ROW_ENCODER_MACROS_SVH
`define PACKBITS_ROW_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PBRE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PBRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pbre_pkg.sv */
// ----------------------------------------------------------------------------
// PackBits row encoder package
// Word types of both channels, the control and status groups between the
// controller and the datapath, and the fixed constants of the encoding.
// ----------------------------------------------------------------------------
package pbre_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_BYTES = 8;
   localparam int LANE_W     = 3;
   // Fourth equal byte in a row turns a literal tail into a run.
   localparam int RUN_START  = 4;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              row_end;
   } pbre_req_type;

   typedef struct packed {
      logic [WORD_BYTES*BYTE_W-1:0] packed_bytes;
      logic [3:0]                   byte_count;
      logic                         burst_last;
      logic                         row_done;
   } pbre_rsp_type;

   // Source of the next encoded byte.
   typedef enum logic [2:0] {
      SEL_PRE_HDR  = 3'd0,
      SEL_PRE_VAL  = 3'd1,
      SEL_LIT_HDR  = 3'd2,
      SEL_LIT_DATA = 3'd3,
      SEL_POST_HDR = 3'd4,
      SEL_POST_VAL = 3'd5
   } pbre_sel_type;

   typedef struct packed {
      logic         accept;
      logic         issue;
      pbre_sel_type sel;
      logic         last;
   } pbre_cmd_type;

   typedef struct packed {
      logic pre_in;
      logic lit_in;
      logic post_in;
      logic has_pre;
      logic has_lit;
      logic has_post;
      logic idx_last;
      logic advance;
   } pbre_sts_type;

endpackage

/* hw/rtl/pbre_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module pbre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pbre_ctrl.sv */
// ----------------------------------------------------------------------------
// PackBits row encoder controller
// Accepts one input word at a time and walks its encoded segments (leading
// run, literal block, trailing run) one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module pbre_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pbre_pkg::pbre_sts_type sts,
   output pbre_pkg::pbre_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_PRE_HDR  = 7'b0000010,
      ST_PRE_VAL  = 7'b0000100,
      ST_LIT_HDR  = 7'b0001000,
      ST_LIT_DATA = 7'b0010000,
      ST_POST_HDR = 7'b0100000,
      ST_POST_VAL = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.accept = req_valid && (state_ff == ST_IDLE);
      cmd.issue  = 1'b0;
      cmd.sel    = pbre_pkg::SEL_PRE_HDR;
      cmd.last   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = sts.pre_in  ? ST_PRE_HDR :
                          sts.lit_in  ? ST_LIT_HDR :
                          sts.post_in ? ST_POST_HDR : ST_IDLE;
            end
         end
         ST_PRE_HDR: begin
            cmd.issue = sts.advance;
            cmd.sel   = pbre_pkg::SEL_PRE_HDR;
            if (sts.advance) begin
               state_in = ST_PRE_VAL;
            end
         end
         ST_PRE_VAL: begin
            cmd.issue = sts.advance;
            cmd.sel   = pbre_pkg::SEL_PRE_VAL;
            cmd.last  = !sts.has_lit && !sts.has_post;
            if (sts.advance) begin
               state_in = sts.has_lit  ? ST_LIT_HDR :
                          sts.has_post ? ST_POST_HDR : ST_IDLE;
            end
         end
         ST_LIT_HDR: begin
            cmd.issue = sts.advance;
            cmd.sel   = pbre_pkg::SEL_LIT_HDR;
            if (sts.advance) begin
               state_in = ST_LIT_DATA;
            end
         end
         ST_LIT_DATA: begin
            cmd.issue = sts.advance;
            cmd.sel   = pbre_pkg::SEL_LIT_DATA;
            cmd.last  = sts.idx_last && !sts.has_post;
            if (sts.advance && sts.idx_last) begin
               state_in = sts.has_post ? ST_POST_HDR : ST_IDLE;
            end
         end
         ST_POST_HDR: begin
            cmd.issue = sts.advance;
            cmd.sel   = pbre_pkg::SEL_POST_HDR;
            if (sts.advance) begin
               state_in = ST_POST_VAL;
            end
         end
         ST_POST_VAL: begin
            cmd.issue = sts.advance;
            cmd.sel   = pbre_pkg::SEL_POST_VAL;
            cmd.last  = 1'b1;
            if (sts.advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/pbre_datapath.sv */
// ----------------------------------------------------------------------------
// PackBits row encoder datapath
// Run and literal bookkeeping, the literal buffer, the byte issue stage,
// the eight-byte packer and the result register.
// ----------------------------------------------------------------------------
module pbre_datapath #(
   parameter int MAX_BLOCK = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pbre_pkg::pbre_cmd_type cmd,
   output pbre_pkg::pbre_sts_type sts,
   input  pbre_pkg::pbre_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pbre_pkg::pbre_rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_BLOCK + 1);
   localparam int AW = $clog2(MAX_BLOCK);
   localparam logic [CW-1:0] BLOCK_MAX = CW'(MAX_BLOCK);
   localparam logic [CW-1:0] RUN_MIN   = CW'(pbre_pkg::RUN_START);
   localparam logic [CW-1:0] KEEP      = CW'(pbre_pkg::RUN_START - 1);

   // Encoder state.
   logic [CW-1:0] lit_cnt_ff,   lit_cnt_in;
   logic [CW-1:0] rep_cnt_ff,   rep_cnt_in;
   logic [7:0]    last_byte_ff, last_byte_in;
   logic          last_ok_ff,   last_ok_in;
   logic          in_run_ff,    in_run_in;

   // Segments that the accepted word produces.
   logic          pre_ff,       pre_in;
   logic [7:0]    pre_hdr_ff,   pre_hdr_in;
   logic [7:0]    pre_byte_ff,  pre_byte_in;
   logic [CW-1:0] lit_n_ff,     lit_n_in;
   logic          post_ff,      post_in;
   logic [7:0]    post_hdr_ff,  post_hdr_in;
   logic [7:0]    post_byte_ff, post_byte_in;
   logic          row_end_ff;

   logic          same;
   logic [CW-1:0] rep_inc;
   logic [CW-1:0] lit_inc;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   logic [AW-1:0] idx_ff;
   logic [7:0]    ram_rdata;
   logic [7:0]    issue_byte;

   logic          s2_valid_ff;
   logic [7:0]    s2_const_ff;
   logic          s2_ram_ff;
   logic          s2_last_ff;
   logic          s2_row_ff;
   logic [7:0]    byte_val;

   logic [pbre_pkg::LANE_W-1:0] lane_ff;
   logic [7:0] lanes_ff  [pbre_pkg::WORD_BYTES];
   logic [7:0] lanes_now [pbre_pkg::WORD_BYTES];
   logic       closing;
   logic       out_free;
   logic       advance;
   logic       push;

   logic                   rsp_valid_ff;
   pbre_pkg::pbre_rsp_type rsp_data_ff;
   pbre_pkg::pbre_rsp_type rsp_data_in;

   always_comb begin
      same    = last_ok_ff && (req_data.data_byte == last_byte_ff);
      rep_inc = rep_cnt_ff + CW'(1);
      lit_inc = lit_cnt_ff + CW'(1);

      lit_cnt_in   = lit_cnt_ff;
      rep_cnt_in   = rep_cnt_ff;
      last_byte_in = last_byte_ff;
      last_ok_in   = last_ok_ff;
      in_run_in    = in_run_ff;
      pre_in       = 1'b0;
      pre_hdr_in   = 8'd1 - 8'(rep_cnt_ff);
      pre_byte_in  = last_byte_ff;
      lit_n_in     = '0;
      post_in      = 1'b0;
      post_hdr_in  = '0;
      post_byte_in = '0;
      wr_en        = 1'b0;
      wr_addr      = lit_cnt_ff[AW-1:0];

      if (in_run_ff) begin
         if (same) begin
            if (rep_inc >= BLOCK_MAX) begin
               // Run is full: close it and start over with nothing pending.
               pre_in      = 1'b1;
               pre_hdr_in  = 8'd1 - 8'(rep_inc);
               in_run_in   = 1'b0;
               last_ok_in  = 1'b0;
               rep_cnt_in  = '0;
               lit_cnt_in  = '0;
            end else begin
               rep_cnt_in = rep_inc;
            end
         end else begin
            // A differing byte closes the run and opens a literal block.
            pre_in       = 1'b1;
            in_run_in    = 1'b0;
            last_byte_in = req_data.data_byte;
            last_ok_in   = 1'b1;
            rep_cnt_in   = CW'(1);
            wr_en        = 1'b1;
            wr_addr      = '0;
            lit_cnt_in   = CW'(1);
         end
      end else begin
         if (same && (rep_inc >= RUN_MIN)) begin
            // The last three literals leave the block and join the new run.
            lit_n_in   = (lit_cnt_ff > KEEP) ? (lit_cnt_ff - KEEP) : '0;
            lit_cnt_in = '0;
            in_run_in  = 1'b1;
            rep_cnt_in = rep_inc;
         end else begin
            wr_en = 1'b1;
            if (lit_inc >= BLOCK_MAX) begin
               lit_n_in   = lit_inc;
               lit_cnt_in = '0;
               rep_cnt_in = '0;
               last_ok_in = 1'b0;
            end else begin
               lit_cnt_in   = lit_inc;
               last_byte_in = req_data.data_byte;
               last_ok_in   = 1'b1;
               rep_cnt_in   = same ? rep_inc : CW'(1);
            end
         end
      end

      if (req_data.row_end) begin
         if (in_run_in) begin
            post_in      = 1'b1;
            post_hdr_in  = 8'd1 - 8'(rep_cnt_in);
            post_byte_in = last_byte_in;
         end else if (lit_cnt_in != '0) begin
            lit_n_in = lit_cnt_in;
         end
         lit_cnt_in   = '0;
         rep_cnt_in   = '0;
         last_byte_in = '0;
         last_ok_in   = 1'b0;
         in_run_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_cnt_ff   <= '0;
         rep_cnt_ff   <= '0;
         last_byte_ff <= '0;
         last_ok_ff   <= 1'b0;
         in_run_ff    <= 1'b0;
         pre_ff       <= 1'b0;
         lit_n_ff     <= '0;
         post_ff      <= 1'b0;
         row_end_ff   <= 1'b0;
      end else if (cmd.accept) begin
         lit_cnt_ff   <= lit_cnt_in;
         rep_cnt_ff   <= rep_cnt_in;
         last_byte_ff <= last_byte_in;
         last_ok_ff   <= last_ok_in;
         in_run_ff    <= in_run_in;
         pre_ff       <= pre_in;
         lit_n_ff     <= lit_n_in;
         post_ff      <= post_in;
         row_end_ff   <= req_data.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pre_hdr_ff   <= pre_hdr_in;
         pre_byte_ff  <= pre_byte_in;
         post_hdr_ff  <= post_hdr_in;
         post_byte_ff <= post_byte_in;
      end
   end

   pbre_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BLOCK)
   ) u_literal_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.data_byte),
      .rd_en   (advance),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Literal read index; cleared with the block header.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.issue && (cmd.sel == pbre_pkg::SEL_LIT_HDR)) begin
         idx_ff <= '0;
      end else if (cmd.issue && (cmd.sel == pbre_pkg::SEL_LIT_DATA)) begin
         idx_ff <= idx_ff + AW'(1);
      end
   end

   always_comb begin
      case (cmd.sel)
         pbre_pkg::SEL_PRE_HDR:  issue_byte = pre_hdr_ff;
         pbre_pkg::SEL_PRE_VAL:  issue_byte = pre_byte_ff;
         pbre_pkg::SEL_LIT_HDR:  issue_byte = 8'(lit_n_ff - CW'(1));
         pbre_pkg::SEL_POST_HDR: issue_byte = post_hdr_ff;
         pbre_pkg::SEL_POST_VAL: issue_byte = post_byte_ff;
         default:                issue_byte = '0;
      endcase
   end

   // Issue stage lines up with the registered buffer read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_const_ff <= issue_byte;
         s2_ram_ff   <= (cmd.sel == pbre_pkg::SEL_LIT_DATA);
         s2_last_ff  <= cmd.last;
         s2_row_ff   <= cmd.last && row_end_ff;
      end
   end

   assign byte_val = s2_ram_ff ? ram_rdata : s2_const_ff;
   assign closing  = s2_valid_ff &&
                     ((lane_ff == pbre_pkg::LANE_W'(pbre_pkg::WORD_BYTES - 1)) || s2_last_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = !closing || out_free;
   assign push     = closing && out_free;

   always_comb begin
      for (int i = 0; i < pbre_pkg::WORD_BYTES; i++) begin
         lanes_now[i] = lanes_ff[i];
      end
      lanes_now[lane_ff] = byte_val;
      for (int i = 0; i < pbre_pkg::WORD_BYTES; i++) begin
         rsp_data_in.packed_bytes[8*i +: 8] = lanes_now[i];
      end
      rsp_data_in.byte_count = {1'b0, lane_ff} + 4'd1;
      rsp_data_in.burst_last = s2_last_ff;
      rsp_data_in.row_done   = s2_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
         for (int i = 0; i < pbre_pkg::WORD_BYTES; i++) begin
            lanes_ff[i] <= '0;
         end
      end else if (s2_valid_ff && advance) begin
         if (closing) begin
            lane_ff <= '0;
            for (int i = 0; i < pbre_pkg::WORD_BYTES; i++) begin
               lanes_ff[i] <= '0;
            end
         end else begin
            lane_ff           <= lane_ff + pbre_pkg::LANE_W'(1);
            lanes_ff[lane_ff] <= byte_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.pre_in   = pre_in;
   assign sts.lit_in   = (lit_n_in != '0);
   assign sts.post_in  = post_in;
   assign sts.has_pre  = pre_ff;
   assign sts.has_lit  = (lit_n_ff != '0);
   assign sts.has_post = post_ff;
   assign sts.idx_last = (CW'(idx_ff) == (lit_n_ff - CW'(1)));
   assign sts.advance  = advance;

endmodule

/* hw/rtl/packbits_row_encoder.sv */
// ----------------------------------------------------------------------------
// PackBits row encoder
// Run-length encodes raster rows, one raw byte per request, into PackBits blocks.
// ----------------------------------------------------------------------------
// Each request word carries one raw byte of a row and a flag that marks the
// last byte. A run of four to MAX_BLOCK equal bytes is sent as the header
// (257 - n) mod 256 and the byte; other bytes go out in literal blocks of up
// to MAX_BLOCK bytes as the header n - 1 and the bytes, which wait in an
// on-chip buffer until the block closes. Encoded bytes are gathered into
// response words of up to eight bytes, first byte in the low bits, with the
// unused upper bytes zero; burst_last marks the final response word that a
// request causes and row_done marks the final word of the row. A request
// that closes nothing yields no response. The request port is ready only
// while the sequencer is idle, so it stays busy while the encoded bytes that
// a request releases go out, since the segment sequencer emits a single byte
// per cycle, read one at a time from the literal buffer for literal blocks,
// and a response stall on the output side pauses the sequencer. Results
// already packed wait in an output register, so the next request is taken
// while they are still pending. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module packbits_row_encoder #(
   parameter int MAX_BLOCK = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pbre_pkg::pbre_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pbre_pkg::pbre_rsp_type rsp_data
);

   // Commands from the sequencer and the status it steers by.
   pbre_pkg::pbre_cmd_type cmd;
   pbre_pkg::pbre_sts_type sts;

   // The controller owns the request handshake and walks the segments of
   // each accepted word: leading run, literal block, trailing run.
   pbre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath keeps the run and literal state, the literal buffer, the
   // byte packer and the response register.
   pbre_datapath #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/pbre_checker.sv */
// ----------------------------------------------------------------------------
// PackBits row encoder checker
// Watches the response port of the encoder over time.
// ----------------------------------------------------------------------------
`include "packbits_row_encoder_macros.svh"

module pbre_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pbre_pkg::pbre_rsp_type rsp_data
);

   // Every response word carries one to eight bytes.
   `PBRE_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, (rsp_data.byte_count != 4'd0) && (rsp_data.byte_count <= 4'd8), "byte count out of range")

   // Only the closing word of a burst may be partly filled.
   `PBRE_ASSERT_IMPL(a_full_inside, clock, reset, rsp_valid && !rsp_data.burst_last, rsp_data.byte_count == 4'd8, "short word inside a burst")

   // The end of a row also ends the burst.
   `PBRE_ASSERT_IMPL(a_row_last, clock, reset, rsp_valid && rsp_data.row_done, rsp_data.burst_last, "row done without burst last")

   // A stalled response word holds.
   `PBRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

bind packbits_row_encoder pbre_checker u_pbre_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
